// ----- sv/asd_pkg.sv -----
// Shared types and constants for the accelerometer step detector.
// Holds the controller state, the datapath command struct and the filter coefficients.
// No dependencies.
package asd_pkg;

  localparam int SAMPLE_BITS_DEF = 14;
  localparam int AXIS_W          = 14;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 23;

  localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY_ALPHA  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK_THRESHOLD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REFRACTORY_MS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_LENGTH    = 3'd4;

  localparam logic [15:0] RST_GRAVITY_ALPHA  = 16'd58982;
  localparam logic [22:0] RST_PEAK_THRESHOLD = 23'd12800;
  localparam logic [15:0] RST_REFRACTORY_MS  = 16'd300;
  localparam logic [9:0]  RST_SAMPLE_PERIOD  = 10'd10;
  localparam logic [7:0]  RST_STEP_LENGTH    = 8'd70;

  // Bandpass coefficients, Q2.14 magnitudes (signs applied by the sequence)
  localparam logic [15:0] COEF_B0  = 16'd3385;
  localparam logic [15:0] COEF_A1N = 16'd22438;
  localparam logic [15:0] COEF_A2  = 16'd9614;

  localparam logic signed [23:0] SIG_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] SIG_MIN = -24'sh800000;

  typedef enum logic [2:0] {
    ST_IDLE, ST_GRAV, ST_SQR, ST_ROOT, ST_FILT, ST_OUT
  } asd_state_t;

  typedef enum logic [2:0] {
    MUL_NONE, MUL_GA, MUL_GB, MUL_SQ, MUL_B0M, MUL_B0M2, MUL_A1Y, MUL_A2Y
  } asd_mul_t;

  typedef enum logic [2:0] {
    ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_SUB, ACC_ADDG
  } asd_acc_t;

  typedef struct packed {
    asd_mul_t   mul;
    asd_acc_t   acc;
    logic [1:0] axis;
    logic       g_upd;
    logic       sq_init;
    logic       sq_step;
    logic       y_upd;
    logic       clr_cnt;
    logic       load_in;
    logic       load_out;
  } asd_cmd_t;

endpackage

// ----- sv/asd_in_if.sv -----
// Sample request channel of the step detector.
// Depends on asd_pkg for the axis width.
interface asd_in_if;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic [asd_pkg::AXIS_W-1:0] accel_x;
  logic [asd_pkg::AXIS_W-1:0] accel_y;
  logic [asd_pkg::AXIS_W-1:0] accel_z;

  modport source (output valid, kind, accel_x, accel_y, accel_z, input ready);
  modport sink   (input valid, kind, accel_x, accel_y, accel_z, output ready);
endinterface

// ----- sv/asd_out_if.sv -----
// Result channel of the step detector.
// No dependencies.
interface asd_out_if;
  logic               valid;
  logic               ready;
  logic               step_detected;
  logic [31:0]        step_total;
  logic [39:0]        distance_total_cm;
  logic signed [23:0] filtered_signal;
  logic               armed;

  modport source (output valid, step_detected, step_total, distance_total_cm,
                  filtered_signal, armed, input ready);
  modport sink   (input valid, step_detected, step_total, distance_total_cm,
                  filtered_signal, armed, output ready);
endinterface

// ----- sv/asd_ctrl.sv -----
// Sequencer of the step detector: handshakes and the micro-step schedule.
// Depends on asd_pkg.
module asd_ctrl #(
  parameter int SAMPLE_BITS = asd_pkg::SAMPLE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_kind,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output asd_pkg::asd_cmd_t cmd
);
  import asd_pkg::*;

  localparam int ROOT_STEPS = SAMPLE_BITS + 9;
  localparam int CW         = $clog2(ROOT_STEPS) + 1;

  asd_state_t    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign in_ready  = (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r + CW'(1);
    cmd           = '0;
    cmd.mul       = MUL_NONE;
    cmd.acc       = ACC_HOLD;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          if (in_kind) begin
            cmd.clr_cnt = 1'b1;
            state_nxt   = ST_OUT;
          end else begin
            state_nxt = ST_GRAV;
          end
        end
      end
      ST_GRAV: begin
        cmd.axis = cnt_r[3:2];
        case (cnt_r[1:0])
          2'd0: cmd.mul = MUL_GA;
          2'd1: begin
            cmd.mul = MUL_GB;
            cmd.acc = ACC_LOAD;
          end
          2'd2: cmd.acc = ACC_ADDG;
          default: cmd.g_upd = 1'b1;
        endcase
        if (cnt_r == CW'(11)) begin
          state_nxt = ST_SQR;
          cnt_nxt   = '0;
        end
      end
      ST_SQR: begin
        case (cnt_r[2:0])
          3'd0: begin
            cmd.mul  = MUL_SQ;
            cmd.axis = 2'd0;
          end
          3'd1: begin
            cmd.mul  = MUL_SQ;
            cmd.axis = 2'd1;
            cmd.acc  = ACC_LOAD;
          end
          3'd2: begin
            cmd.mul  = MUL_SQ;
            cmd.axis = 2'd2;
            cmd.acc  = ACC_ADD;
          end
          3'd3: cmd.acc = ACC_ADD;
          default: begin
            cmd.sq_init = 1'b1;
            state_nxt   = ST_ROOT;
            cnt_nxt     = '0;
          end
        endcase
      end
      ST_ROOT: begin
        cmd.sq_step = 1'b1;
        if (cnt_r == CW'(ROOT_STEPS - 1)) begin
          state_nxt = ST_FILT;
          cnt_nxt   = '0;
        end
      end
      ST_FILT: begin
        case (cnt_r[2:0])
          3'd0: cmd.mul = MUL_B0M;
          3'd1: begin
            cmd.mul = MUL_B0M2;
            cmd.acc = ACC_LOAD;
          end
          3'd2: begin
            cmd.mul = MUL_A1Y;
            cmd.acc = ACC_SUB;
          end
          3'd3: begin
            cmd.mul = MUL_A2Y;
            cmd.acc = ACC_ADD;
          end
          3'd4: cmd.acc = ACC_SUB;
          default: begin
            cmd.y_upd = 1'b1;
            state_nxt = ST_OUT;
          end
        endcase
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ----- sv/asd_dpath.sv -----
// Datapath of the step detector: config registers, shared multiplier and
// accumulator, square-root unit, filter history and step bookkeeping. Depends on asd_pkg.
module asd_dpath #(
  parameter int SAMPLE_BITS = asd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  asd_pkg::asd_cmd_t             cmd,
  input  logic [asd_pkg::AXIS_W-1:0]    accel_x,
  input  logic [asd_pkg::AXIS_W-1:0]    accel_y,
  input  logic [asd_pkg::AXIS_W-1:0]    accel_z,
  input  logic                          cfg_we,
  input  logic [asd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [asd_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                          step_detected,
  output logic [31:0]                   step_total,
  output logic [39:0]                   distance_total_cm,
  output logic signed [23:0]            filtered_signal,
  output logic                          armed
);
  import asd_pkg::*;

  localparam int SB  = SAMPLE_BITS;
  localparam int RW  = (SB > AXIS_W) ? SB : AXIS_W;
  localparam int GW  = SB + 16;
  localparam int DW  = SB + 9;
  localparam int MW  = DW;
  localparam int SQW = 2 * DW;
  localparam int MA  = (DW > 18) ? DW : 18;
  localparam int MB  = GW + 1;
  localparam int PW  = MA + MB;
  localparam int AW  = PW + 2;
  localparam int YW  = AW - 14;

  // configuration
  logic [15:0] alpha_r;
  logic [22:0] thr_r;
  logic [15:0] refr_r;
  logic [9:0]  period_r;
  logic [7:0]  len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r  <= RST_GRAVITY_ALPHA;
      thr_r    <= RST_PEAK_THRESHOLD;
      refr_r   <= RST_REFRACTORY_MS;
      period_r <= RST_SAMPLE_PERIOD;
      len_r    <= RST_STEP_LENGTH;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GRAVITY_ALPHA:  alpha_r  <= cfg_data[15:0];
        CFG_PEAK_THRESHOLD: thr_r    <= cfg_data[22:0];
        CFG_REFRACTORY_MS:  refr_r   <= cfg_data[15:0];
        CFG_SAMPLE_PERIOD:  period_r <= cfg_data[9:0];
        CFG_STEP_LENGTH:    len_r    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // sample capture, low SAMPLE_BITS of each axis
  logic [RW-1:0] ext_x, ext_y, ext_z;
  logic [SB-1:0] raw_r [3];
  assign ext_x = RW'(accel_x);
  assign ext_y = RW'(accel_y);
  assign ext_z = RW'(accel_z);

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      raw_r[0] <= ext_x[SB-1:0];
      raw_r[1] <= ext_y[SB-1:0];
      raw_r[2] <= ext_z[SB-1:0];
    end
  end

  logic [GW-1:0]        g_r [3];
  logic signed [DW-1:0] d_r [3];
  logic signed [PW-1:0] prod_r, prod_c;
  logic signed [AW-1:0] acc_r;
  logic signed [MA-1:0] op_a;
  logic signed [MB-1:0] op_b;
  logic [SQW-1:0]       sq_v_r, sq_res_r, sq_bit_r, sq_t;
  logic [MW-1:0]        mh0_r, mh1_r, mag;
  logic signed [23:0]   oh0_r, oh1_r;

  assign mag = sq_res_r[MW-1:0];

  // shared multiplier operand select
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (cmd.mul)
      MUL_GA: begin
        op_a = MA'($signed({1'b0, alpha_r}));
        op_b = $signed({1'b0, g_r[cmd.axis]});
      end
      MUL_GB: begin
        op_a = MA'($signed({1'b0, 17'(17'h10000 - {1'b0, alpha_r})}));
        op_b = MB'($signed({1'b0, raw_r[cmd.axis]}));
      end
      MUL_SQ: begin
        op_a = MA'(d_r[cmd.axis]);
        op_b = MB'(d_r[cmd.axis]);
      end
      MUL_B0M: begin
        op_a = MA'($signed({1'b0, COEF_B0}));
        op_b = MB'($signed({1'b0, mag}));
      end
      MUL_B0M2: begin
        op_a = MA'($signed({1'b0, COEF_B0}));
        op_b = MB'($signed({1'b0, mh1_r}));
      end
      MUL_A1Y: begin
        op_a = MA'($signed({1'b0, COEF_A1N}));
        op_b = MB'(oh0_r);
      end
      MUL_A2Y: begin
        op_a = MA'($signed({1'b0, COEF_A2}));
        op_b = MB'(oh1_r);
      end
      default: ;
    endcase
  end

  assign prod_c = op_a * op_b;

  always_ff @(posedge clk) begin
    prod_r <= prod_c;
    case (cmd.acc)
      ACC_LOAD: acc_r <= AW'(prod_r);
      ACC_ADD:  acc_r <= acc_r + AW'(prod_r);
      ACC_SUB:  acc_r <= acc_r - AW'(prod_r);
      ACC_ADDG: acc_r <= acc_r + (AW'(prod_r) <<< 16);
      default:  ;
    endcase
  end

  // gravity update and residual
  logic [GW-1:0]      g_new, x_q16;
  logic signed [GW:0] diff;
  assign g_new = acc_r[GW+15:16];
  assign x_q16 = {raw_r[cmd.axis], 16'b0};
  assign diff  = $signed({1'b0, x_q16}) - $signed({1'b0, g_new});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_r[0] <= '0;
      g_r[1] <= '0;
      g_r[2] <= '0;
    end else if (cmd.g_upd) begin
      g_r[cmd.axis] <= g_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.g_upd) begin
      d_r[cmd.axis] <= diff[GW:8];
    end
  end

  // square root, one result bit per cycle
  assign sq_t = sq_res_r + sq_bit_r;

  always_ff @(posedge clk) begin
    if (cmd.sq_init) begin
      sq_v_r   <= acc_r[SQW-1:0];
      sq_res_r <= '0;
      sq_bit_r <= SQW'(1) << (SQW - 2);
    end else if (cmd.sq_step) begin
      if (sq_v_r >= sq_t) begin
        sq_v_r   <= sq_v_r - sq_t;
        sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
      end else begin
        sq_res_r <= sq_res_r >> 1;
      end
      sq_bit_r <= sq_bit_r >> 2;
    end
  end

  // bandpass output, rounding and saturation
  logic signed [AW-1:0] acc_rnd;
  logic signed [YW-1:0] y_full;
  logic [YW-24:0]       y_top;
  logic signed [23:0]   y_sat;
  assign acc_rnd = acc_r + AW'(8192);
  assign y_full  = acc_rnd[AW-1:14];
  assign y_top   = y_full[YW-1:23];

  always_comb begin
    if ((y_top == '0) || (y_top == '1)) begin
      y_sat = y_full[23:0];
    end else if (y_full[YW-1]) begin
      y_sat = SIG_MIN;
    end else begin
      y_sat = SIG_MAX;
    end
  end

  // detector and step bookkeeping
  logic        armed_r, fired_r;
  logic [31:0] clock_r, last_r, count_r, clock_nxt, since;
  logic        arm_now, fire_now;

  assign clock_nxt = clock_r + 32'(period_r);
  assign since     = clock_nxt - last_r;
  assign arm_now   = !armed_r && ($signed({y_sat[23], y_sat}) > $signed({2'b00, thr_r}))
                     && (since > 32'(refr_r));
  assign fire_now  = armed_r && y_sat[23];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mh0_r   <= '0;
      mh1_r   <= '0;
      oh0_r   <= '0;
      oh1_r   <= '0;
      armed_r <= 1'b0;
      fired_r <= 1'b0;
      clock_r <= '0;
      last_r  <= '0;
      count_r <= '0;
    end else if (cmd.clr_cnt) begin
      count_r <= '0;
      fired_r <= 1'b0;
    end else if (cmd.y_upd) begin
      mh1_r   <= mh0_r;
      mh0_r   <= mag;
      oh1_r   <= oh0_r;
      oh0_r   <= y_sat;
      clock_r <= clock_nxt;
      fired_r <= fire_now;
      if (arm_now) begin
        armed_r <= 1'b1;
      end else if (fire_now) begin
        armed_r <= 1'b0;
        count_r <= count_r + 32'd1;
        last_r  <= clock_nxt;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      step_detected     <= fired_r;
      step_total        <= count_r;
      distance_total_cm <= count_r * 40'(len_r);
      filtered_signal   <= oh0_r;
      armed             <= armed_r;
    end
  end

endmodule

// ----- sv/accel_step_detector.sv -----
// Top level of the accelerometer step detector.
// Depends on asd_pkg, asd_in_if, asd_out_if, asd_ctrl and asd_dpath.

// Each request on in_ch is either a three-axis sample (kind 0) or a clear of
// the step count and distance (kind 1); each produces exactly one result on
// out_ch. A sample runs through one shared multiplier and accumulator: gravity
// removal per axis, sum of squares, a bit-serial square root (one result bit
// per cycle) and the bandpass filter with detector update. The next request is
// accepted only once the current one has loaded its result, which is held in
// an output register, so the next request is taken while a result still waits.
// Configuration registers are written through cfg_we/cfg_index/cfg_data and
// should only change while no request is in flight.
module accel_step_detector #(
  parameter int SAMPLE_BITS = asd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  asd_in_if.sink                         in_ch,
  asd_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [asd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [asd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import asd_pkg::*;

  asd_cmd_t cmd;

  // sequencer: owns both handshakes and issues one command per cycle
  asd_ctrl #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_kind   (in_ch.kind),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  // datapath: hold filter state, advance the detector, drive result payload
  asd_dpath #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .accel_x           (in_ch.accel_x),
    .accel_y           (in_ch.accel_y),
    .accel_z           (in_ch.accel_z),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .step_detected     (out_ch.step_detected),
    .step_total        (out_ch.step_total),
    .distance_total_cm (out_ch.distance_total_cm),
    .filtered_signal   (out_ch.filtered_signal),
    .armed             (out_ch.armed)
  );

endmodule
